### rtl/hsnc_pkg.sv
// hsnc_pkg: shared types and constants for the terrain cell normal classifier
// used by every module under rtl

package hsnc_pkg;

    localparam int HW = 16;

    typedef enum logic [1:0] {
        REG_SLOT_SIZE  = 2'd0,
        REG_MAX_HEIGHT = 2'd1,
        REG_FLAT_TOL   = 2'd2,
        REG_STEEP_TOL  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] h0;
        logic [15:0] h1;
        logic [15:0] h2;
        logic [15:0] h3;
        logic        restart;
    } t_cell;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUMSQ,
        ST_SQRT,
        ST_DIV,
        ST_NEXT,
        ST_DOT,
        ST_DONE
    } t_state;

endpackage

### rtl/hsnc_front.sv
// hsnc_front: height scaling stage, one cell per cycle into the queue unless the queue stalls
// depends on hsnc_pkg

module hsnc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_hnl,
    input  logic [7:0]         i_hfl,
    input  logic [7:0]         i_hfr,
    input  logic [7:0]         i_hnr,
    input  logic               i_restart,
    input  logic [15:0]        i_max_height,
    output logic               o_valid,
    input  logic               i_stall,
    output hsnc_pkg::t_cell    o_cell
);
    import hsnc_pkg::*;

    logic   r_valid;
    t_cell  r_cell;

    function automatic logic [15:0] f_scale(input logic [7:0] raw, input logic [15:0] mh);
        logic [23:0] p;
        logic [24:0] t;
        logic [24:0] q;
        begin
            p = raw * mh;
            t = {1'b0, p} + 25'd127;
            // divide by 255 via reciprocal that never overshoots, then fix-up
            q = 25'((49'(t) * 49'd131586) >> 25);
            if (t - q * 25'd255 >= 25'd255) q = q + 25'd1;
            f_scale = q[15:0];
        end
    endfunction

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_cell  = r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_cell.h0      <= f_scale(i_hnl, i_max_height);
            r_cell.h1      <= f_scale(i_hfl, i_max_height);
            r_cell.h2      <= f_scale(i_hfr, i_max_height);
            r_cell.h3      <= f_scale(i_hnr, i_max_height);
            r_cell.restart <= i_restart;
        end
    end
endmodule

### rtl/hsnc_queue.sv
// hsnc_queue: two-entry fifo between front and back
// depends on hsnc_pkg

module hsnc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  hsnc_pkg::t_cell i_cell,
    output logic            o_valid,
    input  logic            i_take,
    output hsnc_pkg::t_cell o_cell
);
    import hsnc_pkg::*;

    t_cell      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cell  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_cell;
    end
endmodule

### rtl/hsnc_back.sv
// hsnc_back: sequencer that normalizes three vectors with one shared
// square root and divider, then the flatness tests; depends on hsnc_pkg

module hsnc_back #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_take,
    input  hsnc_pkg::t_cell i_cell,
    input  logic [15:0]     i_slot_size,
    input  logic [15:0]     i_flat_tol,
    input  logic [15:0]     i_steep_tol,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [15:0]     o_normal_x,
    output logic [15:0]     o_normal_y,
    output logic [15:0]     o_normal_z,
    output logic [15:0]     o_mean_height,
    output logic            o_is_flat,
    output logic [15:0]     o_peak_height
);
    import hsnc_pkg::*;

    localparam int F  = NORMAL_FRAC_BITS;
    // signed component: height differences need 17 bits, the sum vector F+3
    localparam int CW = (F + 3 > 17) ? F + 3 : 17;
    localparam int SW = 2 * CW + 4;     // sum of squares
    localparam int RW = SW + 16;        // radicand
    localparam int LW = RW / 2 + 1;     // root
    localparam int NW = CW + F + 8;     // dividend
    localparam int DW = 2 * F + 4;      // dot product

    t_state r_st, n_st;
    logic signed [CW-1:0] r_c [3];      // vector being normalized
    logic signed [CW-1:0] r_u [3][3];   // results: n0, n1, n
    logic [1:0]  r_vec;
    logic [1:0]  r_comp;
    logic [SW-1:0] r_ss;
    logic [RW-1:0] r_rem;
    logic [LW-1:0] r_root;
    logic [$clog2(RW/2+1)-1:0] r_it;
    logic [NW-1:0] r_num;
    logic [LW:0]   r_part;
    logic [$clog2(NW+1)-1:0] r_dit;
    logic [15:0] r_peak;
    logic [15:0] r_mean;
    logic        r_restart;
    logic        r_ovalid;
    logic signed [DW-1:0] r_dot;
    logic        r_flat;
    logic [15:0] r_ox, r_oy, r_oz, r_omean, r_opeak;

    // one root step
    logic [RW-1:0] w_rad;
    logic [RW-1:0] w_trial;
    logic [RW-1:0] w_rem2;
    logic [LW+1:0] w_pdiv;
    logic [CW-1:0] w_mag;
    logic [CW-1:0] w_mag_sel;
    logic [LW-1:0] w_len;
    logic [NW-1:0] w_q;
    logic [CW-1:0] w_m;
    logic [17:0]   w_hsum;
    logic [15:0]   w_s;
    logic signed [DW-1:0] w_prod;

    assign w_s = (i_slot_size == 16'd0) ? 16'd1 : i_slot_size;
    assign w_len = (r_root == '0) ? LW'(1) : r_root;
    assign w_mag_sel = r_c[r_comp] < 0 ? CW'(-r_c[r_comp]) : CW'(r_c[r_comp]);
    assign w_mag = w_mag_sel;
    assign w_hsum = 18'(i_cell.h0) + 18'(i_cell.h1) + 18'(i_cell.h2)
                  + 18'(i_cell.h3) + 18'd2;

    // radicand bits consumed two at a time, msb first
    assign w_rad   = {r_ss, 16'd0};
    assign w_rem2  = {r_rem[RW-3:0], w_rad[RW-1-2*int'(r_it) -: 2]};
    assign w_trial = RW'({r_root, 2'b01});
    // restoring divide one quotient bit a step: num/len with half-len bias pre-added
    assign w_pdiv = {r_part, r_num[NW-1]};
    assign w_q = r_num;
    assign w_m = (w_q > NW'(1 << F)) ? CW'(1 << F) : CW'(w_q);
    assign w_prod = DW'(r_u[0][r_comp]) * DW'(r_u[1][r_comp]);

    assign o_take = (r_st == ST_IDLE) && i_valid && !(r_ovalid && i_stall);
    assign o_valid = r_ovalid;
    assign o_normal_x = r_ox;
    assign o_normal_y = r_oy;
    assign o_normal_z = r_oz;
    assign o_mean_height = r_omean;
    assign o_is_flat = r_flat;
    assign o_peak_height = r_opeak;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (o_take) n_st = ST_SUMSQ;
            ST_SUMSQ: if (r_comp == 2'd2) n_st = ST_SQRT;
            ST_SQRT:  if (int'(r_it) == RW/2 - 1) n_st = ST_DIV;
            ST_DIV:   if (int'(r_dit) == NW + 1 && r_comp == 2'd2) n_st = ST_NEXT;
            ST_NEXT:  n_st = (r_vec == 2'd2) ? ST_DOT : ST_SUMSQ;
            ST_DOT:   if (r_comp == 2'd2) n_st = ST_DONE;
            ST_DONE:  if (!(r_ovalid && i_stall)) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_peak   <= 16'd0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && !i_stall && r_st != ST_DONE) r_ovalid <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (o_take) begin
                    r_c[0] <= CW'($signed({1'b0, i_cell.h0}) - $signed({1'b0, i_cell.h3}));
                    r_c[1] <= CW'($signed({1'b0, w_s}));
                    r_c[2] <= CW'($signed({1'b0, i_cell.h0}) - $signed({1'b0, i_cell.h1}));
                    r_mean <= w_hsum[17:2];
                    r_restart <= i_cell.restart;
                    r_vec <= 2'd0;
                    r_comp <= 2'd0;
                    r_ss <= '0;
                    r_u[2][0] <= CW'($signed({1'b0, i_cell.h1}) - $signed({1'b0, i_cell.h2}));
                    r_u[2][2] <= CW'($signed({1'b0, i_cell.h3}) - $signed({1'b0, i_cell.h2}));
                end
                ST_SUMSQ: begin
                    r_ss <= r_ss + SW'(w_mag) * SW'(w_mag);
                    r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                    r_rem <= '0;
                    r_root <= '0;
                    r_it <= '0;
                end
                ST_SQRT: begin
                    if (w_rem2 >= w_trial) begin
                        r_rem  <= w_rem2 - w_trial;
                        r_root <= {r_root[LW-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem2;
                        r_root <= {r_root[LW-2:0], 1'b0};
                    end
                    r_it <= r_it + 1'b1;
                    r_comp <= 2'd0;
                    r_dit <= '0;
                end
                ST_DIV: begin
                    if (r_dit == '0) begin
                        r_num  <= (NW'(w_mag) << (F + 8)) + NW'(w_len >> 1);
                        r_part <= '0;
                        r_dit  <= r_dit + 1'b1;
                    end else if (int'(r_dit) <= NW) begin
                        if (w_pdiv >= (LW+2)'(w_len)) begin
                            r_part <= (LW+1)'(w_pdiv - (LW+2)'(w_len));
                            r_num  <= {r_num[NW-2:0], 1'b1};
                        end else begin
                            r_part <= w_pdiv[LW:0];
                            r_num  <= {r_num[NW-2:0], 1'b0};
                        end
                        r_dit <= r_dit + 1'b1;
                    end else begin
                        r_u[r_vec][r_comp] <= (r_c[r_comp] < 0) ? -$signed(w_m) : $signed(w_m);
                        r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                        r_dit <= '0;
                    end
                end
                ST_NEXT: begin
                    r_ss <= '0;
                    r_comp <= 2'd0;
                    r_dot <= '0;
                    if (r_vec == 2'd0) begin
                        r_c[0] <= r_u[2][0];
                        r_c[1] <= CW'($signed({1'b0, w_s}));
                        r_c[2] <= r_u[2][2];
                    end else begin
                        r_c[0] <= r_u[0][0] + r_u[1][0];
                        r_c[1] <= r_u[0][1] + r_u[1][1];
                        r_c[2] <= r_u[0][2] + r_u[1][2];
                    end
                    r_vec <= r_vec + 2'd1;
                end
                ST_DOT: begin
                    r_dot <= r_dot + w_prod;
                    r_comp <= r_comp + 2'd1;
                end
                ST_DONE: if (!(r_ovalid && i_stall)) begin
                    r_ovalid <= 1'b1;
                    r_ox <= 16'(r_u[2][0]);
                    r_oy <= 16'(r_u[2][1]);
                    r_oz <= 16'(r_u[2][2]);
                    r_omean <= r_mean;
                    // signed compares: the rounded dot may exceed one
                    r_flat <= ((((DW+18)'(1) << (2*F)) - (DW+18)'(r_dot)) << 16)
                                < $signed((DW+18)'(i_flat_tol) << (2*F))
                           && (((((DW+18)'(1) << F) - (DW+18)'(r_u[2][1])) << 16)
                                < $signed((DW+18)'(i_steep_tol) << F));
                    if (r_restart) begin
                        r_peak  <= r_mean;
                        r_opeak <= r_mean;
                    end else begin
                        r_peak  <= (r_mean > r_peak) ? r_mean : r_peak;
                        r_opeak <= (r_mean > r_peak) ? r_mean : r_peak;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/heightfield_slot_normal_classifier_top.sv
// top level: terrain cell normal classifier
// depends on hsnc_pkg, hsnc_front, hsnc_queue, hsnc_back
//
//  channel  | handshake            | payload
//  in       | i_valid / o_stall    | four raw corner heights, restart
//  out      | o_valid / i_stall    | normal xyz, mean, flat, peak
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// the back sequencer takes a new cell only once it is done with the last; its shared
// bit-serial square root and divider set the pace
// synchronous active-low reset, peak cleared, registers to defaults
// the front and two-entry queue keep accepting while the back works, until the queue is full

module heightfield_slot_normal_classifier_top #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_height_near_left,
    input  logic [7:0]  i_height_far_left,
    input  logic [7:0]  i_height_far_right,
    input  logic [7:0]  i_height_near_right,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic [15:0] o_mean_height,
    output logic        o_is_flat,
    output logic [15:0] o_peak_height,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import hsnc_pkg::*;

    logic [15:0] r_slot, r_maxh, r_ftol, r_stol;
    logic  w_fv, w_fs, w_qv, w_take;
    t_cell w_fc, w_qc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 16'd256;
            r_maxh <= 16'd12800;
            r_ftol <= 16'd1874;
            r_stol <= 16'd2753;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SLOT_SIZE:  r_slot <= i_cfg_data;
                REG_MAX_HEIGHT: r_maxh <= i_cfg_data;
                REG_FLAT_TOL:   r_ftol <= i_cfg_data;
                REG_STEEP_TOL:  r_stol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hsnc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_hnl(i_height_near_left), .i_hfl(i_height_far_left),
        .i_hfr(i_height_far_right), .i_hnr(i_height_near_right),
        .i_restart(i_restart), .i_max_height(r_maxh),
        .o_valid(w_fv), .i_stall(w_fs), .o_cell(w_fc)
    );

    hsnc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .o_stall(w_fs),
        .i_cell(w_fc), .o_valid(w_qv), .i_take(w_take), .o_cell(w_qc)
    );

    hsnc_back #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_take(w_take),
        .i_cell(w_qc), .i_slot_size(r_slot), .i_flat_tol(r_ftol),
        .i_steep_tol(r_stol), .o_valid(o_valid), .i_stall(i_stall),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_mean_height(o_mean_height), .o_is_flat(o_is_flat),
        .o_peak_height(o_peak_height)
    );
endmodule
